[rtl/core/bba_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared sizes, codes and the command and chain types of the cell row.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CFG_W      = 11;
  localparam int CELL_BITS  = 128;
  localparam int OFS_W      = $clog2(CELL_BITS);
  localparam int NUM_CELLS  = NUM_BLOCKS / CELL_BITS;
  localparam int CELL_W     = IDX_W - OFS_W;
  localparam int PCNT_W     = $clog2(NUM_CELLS + 1);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_EVAL,
    CMD_PROP,
    CMD_SET,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e             op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] hint;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic             a_found;
    logic [IDX_W-1:0] a_idx;
    logic             b_found;
    logic [IDX_W-1:0] b_idx;
  } hit_t;

endpackage

[rtl/core/bba_cell.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator cell
// Holds one slice of the used map, finds its lowest free block and merges
// its finding with the result handed down from the cell above.
// ----------------------------------------------------------------------------
module bba_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bba_pkg::CELL_W-1:0] cell_id_i,
  input  bba_pkg::cmd_t              cmd_i,
  input  bba_pkg::hit_t              hit_i,
  output bba_pkg::hit_t              hit_o
);
  import bba_pkg::*;

  logic [CELL_BITS-1:0] word_q;
  hit_t                 loc_d;
  hit_t                 loc_q;
  hit_t                 best_q;
  logic                 mine;

  assign mine = (cmd_i.idx[IDX_W-1:OFS_W] == cell_id_i);

  // The loop runs downward so that the lowest free block of the slice wins.
  always_comb begin
    logic [IDX_W-1:0] gidx;
    logic             avail;
    loc_d = '0;
    for (int j = CELL_BITS - 1; j >= 0; j--) begin
      gidx  = {cell_id_i, OFS_W'(j)};
      avail = !word_q[j] && ({1'b0, gidx} < cmd_i.count);
      if (avail) begin
        loc_d.b_found = 1'b1;
        loc_d.b_idx   = gidx;
        if (gidx >= cmd_i.hint) begin
          loc_d.a_found = 1'b1;
          loc_d.a_idx   = gidx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (mine && cmd_i.op == CMD_SET) begin
      word_q[cmd_i.idx[OFS_W-1:0]] <= 1'b1;
    end else if (mine && cmd_i.op == CMD_CLEAR) begin
      word_q[cmd_i.idx[OFS_W-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_EVAL) begin
      loc_q  <= loc_d;
      best_q <= loc_d;
    end else if (cmd_i.op == CMD_PROP) begin
      best_q.a_found <= loc_q.a_found || hit_i.a_found;
      best_q.a_idx   <= loc_q.a_found ? loc_q.a_idx : hit_i.a_idx;
      best_q.b_found <= loc_q.b_found || hit_i.b_found;
      best_q.b_idx   <= loc_q.b_found ? loc_q.b_idx : hit_i.b_idx;
    end
  end

  assign hit_o = best_q;

endmodule

[rtl/core/bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Next-fit block allocator over a used map kept in a row of cells.
// ----------------------------------------------------------------------------
// The used map lives in NUM_CELLS cells of CELL_BITS blocks each. An allocate
// passes through S_EVAL, in which every cell finds its lowest free block,
// then S_PROP, in which the findings travel down the row from cell to cell
// to cell 0, then S_FIN, which commits the grant once the output register
// is free. A free goes straight to S_FIN. One request is worked on at a time;
// a finished result waits in the output register while the next request
// is taken. After reset every block is free, the search hint is zero and
// block_count is 1024.
module bitmap_block_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [bba_pkg::CFG_W-1:0] cfg_wr_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [bba_pkg::IDX_W-1:0] free_index_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bba_pkg::IDX_W-1:0] granted_index_o,
  output logic [1:0]                status_o
);
  import bba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_PROP,
    S_FIN
  } state_e;

  state_e              state_q;
  logic [CFG_W-1:0]    block_count_q;
  logic [IDX_W-1:0]    hint_q;
  op_e                 op_q;
  logic [IDX_W-1:0]    idx_q;
  logic [PCNT_W-1:0]   pcnt_q;
  logic                out_valid_q;
  logic [IDX_W-1:0]    granted_q;
  status_e             status_q;

  logic [CNT_W-1:0]    count;
  logic                slot_free;
  logic                in_range;
  hit_t                res;
  cmd_t                cmd;
  hit_t                chain [NUM_CELLS+1];

  assign count = (block_count_q > CFG_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                      : CNT_W'(block_count_q);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_range  = ({1'b0, idx_q} < count);
  assign res       = chain[0];
  assign chain[NUM_CELLS] = '0;

  always_comb begin
    cmd       = '0;
    cmd.op    = CMD_IDLE;
    cmd.hint  = hint_q;
    cmd.count = count;
    cmd.idx   = idx_q;
    unique case (state_q)
      S_EVAL: cmd.op = CMD_EVAL;
      S_PROP: cmd.op = CMD_PROP;
      S_FIN: begin
        if (slot_free) begin
          if (op_q == OP_FREE) begin
            if (in_range) begin
              cmd.op = CMD_CLEAR;
            end
          end else if (res.a_found) begin
            cmd.op  = CMD_SET;
            cmd.idx = res.a_idx;
          end else if (res.b_found) begin
            cmd.op  = CMD_SET;
            cmd.idx = res.b_idx;
          end
        end
      end
      default: cmd.op = CMD_IDLE;
    endcase
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    bba_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cell_id_i(CELL_W'(k)),
      .cmd_i    (cmd),
      .hit_i    (chain[k+1]),
      .hit_o    (chain[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      block_count_q <= CFG_RESET;
      hint_q        <= '0;
      pcnt_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        block_count_q <= cfg_wr_data_i;
      end
      if (state_q == S_FIN && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= (op_e'(operation_i) == OP_FREE) ? S_FIN : S_EVAL;
          end
        end
        S_EVAL: begin
          pcnt_q  <= '0;
          state_q <= S_PROP;
        end
        S_PROP: begin
          pcnt_q <= pcnt_q + 1'b1;
          if (pcnt_q == PCNT_W'(NUM_CELLS - 1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            state_q <= S_IDLE;
            if (cmd.op == CMD_SET) begin
              hint_q <= cmd.idx;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q  <= op_e'(operation_i);
      idx_q <= free_index_i;
    end
    if (state_q == S_FIN && slot_free) begin
      if (op_q == OP_FREE) begin
        granted_q <= '0;
        status_q  <= in_range ? ST_OK : ST_RANGE;
      end else if (cmd.op == CMD_SET) begin
        granted_q <= cmd.idx;
        status_q  <= ST_OK;
      end else begin
        granted_q <= '0;
        status_q  <= ST_FULL;
      end
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign granted_index_o = granted_q;
  assign status_o        = status_q;

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate and free requests with random gaps and output stalls,
// predicts each result from a private copy of the used map, the search hint
// and the block count, and checks every result transfer field by field.
// ----------------------------------------------------------------------------
module tb;
  import bba_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic [IDX_W-1:0] index;
    status_e          status;
  } grant_t;

  class alloc_scoreboard;
    logic [NUM_BLOCKS-1:0] used_map;
    int                    hint;
    int                    count;
    int                    errors;
    grant_t                expected[$];

    function new();
      used_map = '0;
      hint     = 0;
      count    = NUM_BLOCKS;
      errors   = 0;
    endfunction

    function void set_count(logic [CFG_W-1:0] value);
      count = (value > NUM_BLOCKS) ? NUM_BLOCKS : int'(value);
    endfunction

    function void note_request(op_e op, logic [IDX_W-1:0] idx);
      grant_t e;
      int     i;
      int     hit;
      bit     found;
      e.index  = '0;
      e.status = ST_OK;
      found    = 1'b0;
      hit      = 0;
      if (op == OP_ALLOC) begin
        for (i = hint; i < count && !found; i++) begin
          if (!used_map[i]) begin
            hit   = i;
            found = 1'b1;
          end
        end
        for (i = 0; i < count && !found; i++) begin
          if (!used_map[i]) begin
            hit   = i;
            found = 1'b1;
          end
        end
        if (found) begin
          hint          = hit;
          used_map[hit] = 1'b1;
          e.index       = IDX_W'(hit);
        end else begin
          e.status = ST_FULL;
        end
      end else begin
        if (int'(idx) < count) begin
          used_map[idx] = 1'b0;
        end else begin
          e.status = ST_RANGE;
        end
      end
      expected.push_back(e);
    endfunction

    function void check_result(logic [IDX_W-1:0] index, logic [1:0] status);
      grant_t e;
      if (expected.size() == 0) begin
        $error("Unexpected result transfer: granted_index %0d, status %0d", index, status);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (index !== e.index) begin
        $error("granted_index: expected %0d, actual %0d", e.index, index);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_wr_en_i   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data_i = '0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic             operation_i   = 1'b0;
  logic [IDX_W-1:0] free_index_i  = '0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic [IDX_W-1:0] granted_index_o;
  logic [1:0]       status_o;

  alloc_scoreboard sb = new();
  bit              in_burst  = 1'b0;
  bit              out_burst = 1'b0;
  int unsigned     quiet_cycles = 0;

  bitmap_block_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .free_index_i   (free_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_index_o(granted_index_o),
    .status_o       (status_o)
  );

  always #1 clk_i = ~clk_i;

  always_ff @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int stall;
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(granted_index_o, status_o);
    end
  end

  task automatic send_request(input op_e op, input logic [IDX_W-1:0] idx);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    free_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, idx);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    sb.set_count(value);
  endtask

  initial begin
    int               phase;
    int               n;
    int               sel;
    int               cnt;
    int               top;
    int               alloc_pct;
    logic [CFG_W-1:0] value;
    logic [IDX_W-1:0] idx;
    op_e              op;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, IDX_W'(1023));
    send_request(OP_FREE, '0);
    send_request(OP_ALLOC, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, IDX_W'(1));
    drain();

    write_count(CFG_W'(4));
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, IDX_W'(5));
    send_request(OP_FREE, IDX_W'(1023));
    send_request(OP_FREE, IDX_W'(2));
    send_request(OP_FREE, IDX_W'(2));
    send_request(OP_ALLOC, '0);
    drain();

    write_count('0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '0);
    drain();

    write_count('1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, IDX_W'(1023));
    drain();

    for (phase = 0; phase < 16; phase++) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: value = CFG_W'(1);
        1: value = CFG_W'(NUM_BLOCKS);
        2: value = CFG_W'($urandom_range(NUM_BLOCKS + 1, 2047));
        3: value = CFG_W'($urandom_range(2, 64));
        4: value = CFG_W'($urandom_range(65, 1023));
        default: value = CFG_W'($urandom_range(1, 1023));
      endcase
      write_count(value);
      cnt       = (value > NUM_BLOCKS) ? NUM_BLOCKS : int'(value);
      top       = (cnt + 3 > 1023) ? 1023 : cnt + 3;
      alloc_pct = $urandom_range(40, 95);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 115; n++) begin
        op = ($urandom_range(1, 100) <= alloc_pct) ? OP_ALLOC : OP_FREE;
        if ($urandom_range(0, 3) != 0) begin
          idx = IDX_W'($urandom_range(0, top));
        end else begin
          idx = IDX_W'($urandom_range(0, 1023));
        end
        send_request(op, idx);
      end
      drain();
    end

    in_burst  = 1'b0;
    out_burst = 1'b0;
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bba_pkg.sv
rtl/core/bba_cell.sv
rtl/core/bitmap_block_allocator.sv
bench/tb.sv
